// ----- design/ctkq_pkg.sv -----
// shared types and constants for the touch key event qualifier
package ctkq_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_RECIP,
    S_FIX,
    S_DECIDE,
    S_CALDIV,
    S_CALFIX,
    S_SCAN,
    S_FLAGS,
    S_DONE
  } ctkq_state_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_RISE = 2'd1,
    EV_HELD = 2'd2,
    EV_REL  = 2'd3
  } ctkq_event_t;

  typedef enum logic [2:0] {
    REG_THRESH    = 3'd0,
    REG_SHORT_MIN = 3'd1,
    REG_SHORT_MAX = 3'd2,
    REG_LONG      = 3'd3,
    REG_RAW_ALPHA = 3'd4,
    REG_DIF_ALPHA = 3'd5
  } ctkq_reg_t;

  typedef enum logic [1:0] {
    FLT_CHARGED = 2'd0,
    FLT_DISCHG  = 2'd1,
    FLT_DIFF    = 2'd2
  } ctkq_flt_t;

  localparam int unsigned MUL_W     = 27;
  localparam logic [6:0]  ALPHA_MAX = 7'd100;
  // ceil(2^31 / 100), exact for dividends below about 4e7
  localparam logic [MUL_W-1:0] RECIP_100 = 27'd21474837;
  localparam int unsigned RECIP_SH  = 31;
  // magnitude bits of the calibration sum
  localparam int unsigned CAL_MAG_W = 25;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } ctkq_mul_op_t;

endpackage

// ----- design/ctkq_mul.sv -----
// shared unsigned multiplier with registered product
module ctkq_mul
  import ctkq_pkg::*;
(
  input  logic                   clk,
  input  ctkq_mul_op_t           op,
  output logic [2*MUL_W-1:0]     prod_r
);

  logic [2*MUL_W-1:0] prod_nxt;

  assign prod_nxt = {{MUL_W{1'b0}}, op.a} * {{MUL_W{1'b0}}, op.b};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- design/cap_touch_key_event_qualifier_core.sv -----
// touch key event qualifier: iir smoothing, calibration and press classification
// from accept to out_valid: each of the three smoothers passes through scale, recip and fix,
//   then decide; a scan goes on through scan and flags, a calibration through caldiv and
//   calfix only when it closes a calibration block, an out-of-range key straight to done
// one transaction at a time, taken only in the idle state; a result still stalled at the
//   output holds the next one in the done state; the shared multiplier runs each of the
//   three smoothers in two passes (alpha scale, then divide by 100 by reciprocal)
// reset: synchronous active-low rst_n clears all per-key state and loads register defaults
module cap_touch_key_event_qualifier_core
  import ctkq_pkg::*;
#(
  parameter int KEYS        = 2,
  parameter int CAL_SAMPLES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [2:0]         in_key,
  input  logic [15:0]        in_sum_charged,
  input  logic [15:0]        in_sum_discharged,
  input  logic [31:0]        in_stamp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_key_out,
  output logic               out_touched,
  output logic [1:0]         out_event_res,
  output logic [30:0]        out_hold_time,
  output logic               out_short_press,
  output logic               out_short_alone,
  output logic               out_long_press,
  output logic               out_held_press,
  output logic               out_timer_in_use,
  output logic signed [16:0] out_smoothed_diff,
  output logic signed [17:0] out_touch_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int KW     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam int ACC_W  = CAL_MAG_W + 1;
  localparam int CAL_L  = $clog2(CAL_SAMPLES);
  localparam int CAL_SH = CAL_MAG_W + CAL_L;
  localparam logic [63:0] CAL_M64 =
    ((64'd1 << CAL_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [MUL_W-1:0] CAL_M = CAL_M64[MUL_W-1:0];
  localparam logic [3:0] KEYS_C = 4'(KEYS);
  localparam logic [CNT_W-1:0] CAL_C = CNT_W'(CAL_SAMPLES);

  // configuration
  logic [15:0] thresh_r, smin_r, smax_r, long_r;
  logic [6:0]  raw_alpha_r, dif_alpha_r;

  // per-key state
  logic signed [16:0]      cf_r   [KEYS];
  logic signed [16:0]      df_r   [KEYS];
  logic signed [17:0]      dff_r  [KEYS];
  logic signed [ACC_W-1:0] cacc_r [KEYS];
  logic [CNT_W-1:0]        ccnt_r [KEYS];
  logic signed [17:0]      lvl_r  [KEYS];
  logic                    last_r [KEYS];
  logic [31:0]             start_r[KEYS];
  logic [30:0]             dur_r  [KEYS];
  logic                    lf_r   [KEYS];
  logic [KEYS-1:0]         mask_r;

  // transaction registers
  ctkq_state_t        state_r, state_nxt;
  ctkq_flt_t          fsel_r;
  logic               op_r;
  logic [2:0]         key_r;
  logic               kok_r;
  logic [15:0]        sc_r, sd_r;
  logic [31:0]        stamp_r;
  logic signed [17:0] fc_r, fd_r, d_r;
  logic               esign_r, tsign_r;
  logic               touched_r, sp_r, sa_r, lp_r, hp_r;
  ctkq_event_t        ev_r;

  logic               out_valid_r;
  logic [2:0]         o_key_r;
  logic               o_touched_r, o_sp_r, o_sa_r, o_lp_r, o_hp_r, o_timer_r;
  logic [1:0]         o_ev_r;
  logic [30:0]        o_hold_r;
  logic signed [16:0] o_diff_r;
  logic signed [17:0] o_lvl_r;

  logic [KW-1:0] k;
  assign k = key_r[KW-1:0];

  // shared multiplier
  ctkq_mul_op_t        mop;
  logic [2*MUL_W-1:0]  prod_r;

  ctkq_mul u_mul (
    .clk    (clk),
    .op     (mop),
    .prod_r (prod_r)
  );

  // smoother operand selection
  logic signed [17:0] x_sel, acc_sel;
  logic signed [18:0] e_val;
  logic [18:0]        e_mag;
  logic [6:0]         alpha_sel, alpha_cl;
  logic signed [27:0] t_val;
  logic [26:0]        t_mag;
  logic [20:0]        q_flt;
  logic signed [18:0] r_flt;
  logic [ACC_W-1:0]   cal_mag;
  logic [16:0]        q_cal;
  logic signed [18:0] avg_cal, lvl_new;
  logic signed [ACC_W-1:0] acc_new;
  logic [CNT_W-1:0]   cnt_new;
  logic               touched_c;
  ctkq_event_t        ev_c;
  logic [31:0]        dt;
  logic               others_zero;
  logic               go_done;

  always_comb begin
    case (fsel_r)
      FLT_CHARGED: begin
        x_sel   = $signed({2'b00, sc_r});
        acc_sel = 18'(cf_r[k]);
        alpha_sel = raw_alpha_r;
      end
      FLT_DISCHG: begin
        x_sel   = $signed({2'b00, sd_r});
        acc_sel = 18'(df_r[k]);
        alpha_sel = raw_alpha_r;
      end
      default: begin
        x_sel   = 18'(fc_r - fd_r);
        acc_sel = dff_r[k];
        alpha_sel = dif_alpha_r;
      end
    endcase
  end

  always_comb begin
    alpha_cl = (alpha_sel > ALPHA_MAX) ? ALPHA_MAX : alpha_sel;
    e_val    = 19'(x_sel) - 19'(acc_sel);
    e_mag    = e_val[18] ? 19'(-e_val) : 19'(e_val);
    t_val    = (28'(acc_sel) <<< 6) + (28'(acc_sel) <<< 5) + (28'(acc_sel) <<< 2)
             + (esign_r ? -$signed({2'b00, prod_r[25:0]}) : $signed({2'b00, prod_r[25:0]}));
    t_mag    = t_val[27] ? 27'(-t_val) : 27'(t_val);
    q_flt    = prod_r[RECIP_SH +: 21];
    r_flt    = tsign_r ? -$signed({1'b0, q_flt[17:0]}) : $signed({1'b0, q_flt[17:0]});
    cal_mag  = cacc_r[k][ACC_W-1] ? ACC_W'(-cacc_r[k]) : ACC_W'(cacc_r[k]);
    q_cal    = prod_r[CAL_SH +: 17];
    avg_cal  = cacc_r[k][ACC_W-1] ? -$signed({2'b00, q_cal}) : $signed({2'b00, q_cal});
    lvl_new  = avg_cal - $signed({3'b000, thresh_r});
    acc_new  = cacc_r[k] + ACC_W'(d_r);
    cnt_new  = ccnt_r[k] + CNT_W'(1);
  end

  // scan decision
  always_comb begin
    touched_c = lvl_r[k] > d_r;
    if (!last_r[k] && touched_c) begin
      ev_c = EV_RISE;
    end else if (last_r[k] && !touched_c) begin
      ev_c = EV_REL;
    end else if (last_r[k] && touched_c) begin
      ev_c = EV_HELD;
    end else begin
      ev_c = EV_NONE;
    end
    dt = stamp_r - start_r[k];
  end

  always_comb begin
    others_zero = 1'b1;
    for (int i = 0; i < KEYS; i++) begin
      if (KW'(i) != k && dur_r[i] != 31'd0) begin
        others_zero = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = ({1'b0, in_key} < KEYS_C) ? S_SCALE : S_DONE;
        end
      end
      S_SCALE: state_nxt = S_RECIP;
      S_RECIP: state_nxt = S_FIX;
      S_FIX:   state_nxt = (fsel_r == FLT_DIFF) ? S_DECIDE : S_SCALE;
      S_DECIDE: begin
        if (op_r) begin
          state_nxt = S_SCAN;
        end else if (cnt_new >= CAL_C) begin
          state_nxt = S_CALDIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CALDIV: state_nxt = S_CALFIX;
      S_CALFIX: state_nxt = S_DONE;
      S_SCAN:   state_nxt = S_FLAGS;
      S_FLAGS:  state_nxt = S_DONE;
      S_DONE:   state_nxt = go_done ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    cfg_ready = 1'b1;
    go_done   = (state_r == S_DONE) && (!out_valid_r || !out_stall);
    mop.a     = '0;
    mop.b     = '0;
    case (state_r)
      S_SCALE: begin
        mop.a = MUL_W'(e_mag);
        mop.b = MUL_W'(alpha_cl);
      end
      S_RECIP: begin
        mop.a = t_mag;
        mop.b = RECIP_100;
      end
      S_CALDIV: begin
        mop.a = MUL_W'(cal_mag);
        mop.b = CAL_M;
      end
      default: begin
        mop.a = '0;
        mop.b = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= 16'd50;
      smin_r      <= 16'd50;
      smax_r      <= 16'd1000;
      long_r      <= 16'd2000;
      raw_alpha_r <= 7'd100;
      dif_alpha_r <= 7'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESH:    thresh_r    <= cfg_data;
        REG_SHORT_MIN: smin_r      <= cfg_data;
        REG_SHORT_MAX: smax_r      <= cfg_data;
        REG_LONG:      long_r      <= cfg_data;
        REG_RAW_ALPHA: raw_alpha_r <= cfg_data[6:0];
        REG_DIF_ALPHA: dif_alpha_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fsel_r      <= FLT_CHARGED;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      for (int i = 0; i < KEYS; i++) begin
        cf_r[i]    <= '0;
        df_r[i]    <= '0;
        dff_r[i]   <= '0;
        cacc_r[i]  <= '0;
        ccnt_r[i]  <= '0;
        lvl_r[i]   <= '0;
        last_r[i]  <= 1'b0;
        start_r[i] <= '0;
        dur_r[i]   <= '0;
        lf_r[i]    <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (go_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_op;
            key_r     <= in_key;
            kok_r     <= ({1'b0, in_key} < KEYS_C);
            sc_r      <= in_sum_charged;
            sd_r      <= in_sum_discharged;
            stamp_r   <= in_stamp;
            fsel_r    <= FLT_CHARGED;
            touched_r <= 1'b0;
            ev_r      <= EV_NONE;
            sp_r      <= 1'b0;
            sa_r      <= 1'b0;
            lp_r      <= 1'b0;
            hp_r      <= 1'b0;
          end
        end
        S_SCALE: esign_r <= e_val[18];
        S_RECIP: tsign_r <= t_val[27];
        S_FIX: begin
          case (fsel_r)
            FLT_CHARGED: begin
              cf_r[k] <= r_flt[16:0];
              fc_r    <= r_flt[17:0];
              fsel_r  <= FLT_DISCHG;
            end
            FLT_DISCHG: begin
              df_r[k] <= r_flt[16:0];
              fd_r    <= r_flt[17:0];
              fsel_r  <= FLT_DIFF;
            end
            default: begin
              dff_r[k] <= r_flt[17:0];
              d_r      <= r_flt[17:0];
            end
          endcase
        end
        S_DECIDE: begin
          if (!op_r) begin
            cacc_r[k] <= acc_new;
            ccnt_r[k] <= cnt_new;
          end
        end
        S_CALFIX: begin
          lvl_r[k]  <= lvl_new[17:0];
          cacc_r[k] <= '0;
          ccnt_r[k] <= '0;
        end
        S_SCAN: begin
          touched_r <= touched_c;
          ev_r      <= ev_c;
          last_r[k] <= touched_c;
          case (ev_c)
            EV_RISE: begin
              lf_r[k]    <= 1'b0;
              mask_r[k]  <= 1'b1;
              start_r[k] <= stamp_r;
            end
            EV_HELD, EV_REL: begin
              if (!dt[31]) begin
                dur_r[k] <= dt[30:0];
              end
              if (ev_c == EV_REL) begin
                start_r[k] <= stamp_r;
                mask_r[k]  <= 1'b0;
              end
            end
            default: begin
              dur_r[k]   <= '0;
              start_r[k] <= '0;
            end
          endcase
        end
        S_FLAGS: begin
          if (ev_r == EV_REL && dur_r[k] >= 31'(smin_r) && dur_r[k] <= 31'(smax_r)) begin
            sp_r <= 1'b1;
            sa_r <= others_zero;
          end
          if (dur_r[k] > 31'(long_r) && !lf_r[k]) begin
            lf_r[k] <= 1'b1;
            lp_r    <= 1'b1;
          end
          if (ev_r == EV_HELD && dur_r[k] > 31'(smin_r)) begin
            hp_r <= 1'b1;
          end
        end
        S_DONE: begin
          if (go_done) begin
            o_key_r     <= key_r;
            o_touched_r <= touched_r;
            o_ev_r      <= ev_r;
            o_sp_r      <= sp_r;
            o_sa_r      <= sa_r;
            o_lp_r      <= lp_r;
            o_hp_r      <= hp_r;
            o_timer_r   <= (mask_r != '0);
            o_hold_r    <= kok_r ? dur_r[k] : '0;
            o_diff_r    <= kok_r ? d_r[16:0] : '0;
            o_lvl_r     <= kok_r ? lvl_r[k] : '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_out       = o_key_r;
  assign out_touched       = o_touched_r;
  assign out_event_res     = o_ev_r;
  assign out_hold_time     = o_hold_r;
  assign out_short_press   = o_sp_r;
  assign out_short_alone   = o_sa_r;
  assign out_long_press    = o_lp_r;
  assign out_held_press    = o_hp_r;
  assign out_timer_in_use  = o_timer_r;
  assign out_smoothed_diff = o_diff_r;
  assign out_touch_level   = o_lvl_r;

endmodule

// ----- design/ctkq_checker.sv -----
// port-level checker for the touch key event qualifier, with its bind
module ctkq_checker
  import ctkq_pkg::*;
#(
  parameter int KEYS = 2
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_key_out,
  input logic               out_touched,
  input logic [1:0]         out_event_res,
  input logic [30:0]        out_hold_time,
  input logic               out_short_press,
  input logic               out_short_alone,
  input logic               out_held_press
);

  localparam logic [3:0] KEYS_C = 4'(KEYS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_bad_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ({1'b0, out_key_out} >= KEYS_C) |->
      !out_touched && out_event_res == EV_NONE && out_hold_time == 31'd0)
    else $error("out-of-range key reported activity");

  a_short_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_press |-> out_event_res == EV_REL)
    else $error("short press without release");

  a_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_alone |-> out_short_press)
    else $error("lone short press without short press");

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_held_press |-> out_event_res == EV_HELD && out_touched)
    else $error("held press outside a held touch");

endmodule

bind cap_touch_key_event_qualifier_core ctkq_checker #(.KEYS(KEYS)) u_ctkq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_key_out     (out_key_out),
  .out_touched     (out_touched),
  .out_event_res   (out_event_res),
  .out_hold_time   (out_hold_time),
  .out_short_press (out_short_press),
  .out_short_alone (out_short_alone),
  .out_held_press  (out_held_press)
);
